[rtl/mro_pkg.sv]
// Shared constants, types and state codes for the maximal rectangle block.
package mro_pkg;

  localparam int MaxCols   = 256;
  localparam int MaxRows   = 256;
  localparam int ColW      = $clog2(MaxCols);
  localparam int CntW      = $clog2(MaxCols + 1);
  localparam int HgtW      = $clog2(MaxRows + 1);
  localparam int AreaW     = 17;
  localparam int ProdW     = HgtW + CntW;
  localparam int AreaLimit = (1 << AreaW) - 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_RD   = 6'b000100,
    S_CMP  = 6'b001000,
    S_POP  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  // One stack entry: the leftmost column a bar extends to, and its height.
  typedef struct packed {
    logic [ColW-1:0] start;
    logic [HgtW-1:0] height;
  } stack_entry_t;

  // A popped bar handed to the area unit.
  typedef struct packed {
    logic            fire;
    logic [HgtW-1:0] height;
    logic [CntW-1:0] width;
  } pop_t;

endpackage

[rtl/mro_height_mem.sv]
// Column height memory with per-entry valid bits that all clear together on reset or clear.
module mro_height_mem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      wr_en,
  input  logic [mro_pkg::ColW-1:0]  wr_addr,
  input  logic [mro_pkg::HgtW-1:0]  wr_data,
  input  logic                      rd_en,
  input  logic [mro_pkg::ColW-1:0]  rd_addr,
  output logic [mro_pkg::HgtW-1:0]  rd_data
);

  logic [mro_pkg::HgtW-1:0] mem [mro_pkg::MaxCols];
  logic [mro_pkg::MaxCols-1:0] vld;
  logic [mro_pkg::HgtW-1:0] q;
  logic                     qv;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
      qv  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        qv <= vld[rd_addr];
      end
    end
  end

  // An entry never written since the last clear reads as zero height.
  assign rd_data = qv ? q : '0;

endmodule

[rtl/mro_stack_mem.sv]
// Index stack memory: one write port and one registered read port.
module mro_stack_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [mro_pkg::ColW-1:0]    wr_addr,
  input  mro_pkg::stack_entry_t       wr_data,
  input  logic                        rd_en,
  input  logic [mro_pkg::ColW-1:0]    rd_addr,
  output mro_pkg::stack_entry_t       rd_data
);

  mro_pkg::stack_entry_t mem [mro_pkg::MaxCols];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/mro_area_unit.sv]
// Shared multiplier that turns each popped bar into an area and keeps the best.
module mro_area_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  mro_pkg::pop_t               pop,
  output logic [mro_pkg::AreaW-1:0]   best_next
);

  logic [mro_pkg::ProdW-1:0] prod;
  logic                      prod_v;
  logic [mro_pkg::AreaW-1:0] best;
  logic [mro_pkg::AreaW-1:0] sat;

  always_ff @(posedge clk) begin
    if (pop.fire) begin
      prod <= mro_pkg::ProdW'(pop.height) * mro_pkg::ProdW'(pop.width);
    end
  end

  always_comb begin
    if (prod > mro_pkg::ProdW'(mro_pkg::AreaLimit)) begin
      sat = mro_pkg::AreaW'(mro_pkg::AreaLimit);
    end else begin
      sat = prod[mro_pkg::AreaW-1:0];
    end
    best_next = (prod_v && (sat > best)) ? sat : best;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prod_v <= 1'b0;
      best   <= '0;
    end else begin
      prod_v <= pop.fire;
      best   <= best_next;
    end
  end

endmodule

[rtl/maximal_rectangle_of_ones.sv]
// Top level: cell intake, column heights and the stack-based histogram sequencer.
//
// Usage: the matrix arrives one cell per transfer on the input channel
// (cell_bit, final_cell) in row-major order; cfg_write_en/cfg_write_data set the
// row length (0 acts as 1, above 256 acts as 256; reset value 256). Write it
// only while the block is idle. After the transfer that carries final_cell the
// block presents largest_area on the output channel and clears its matrix state.
// Sequence: a cell inside a row is accepted, then its height is updated in the
// column memory. A cell that closes a row, or the final cell, also runs the
// histogram scan: per column a registered memory read and the compare, per
// stack pop the compare and then a reload of the new stack top from the stack
// memory, then the closing pass and a finish state. Each column is popped at
// most once, and input stall is high throughout. The result is registered in
// the finish state after the scan of the final row. It waits in an output
// register while out_stall is high; the next matrix can be fed meanwhile, and
// only its own final cell waits for that register to empty. Synchronous reset
// clears the heights (through valid bits), the running best and the output
// channel.
module maximal_rectangle_of_ones (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [8:0]                 cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cell_bit,
  input  logic                       final_cell,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [16:0]                largest_area
);

  localparam int ColW = mro_pkg::ColW;
  localparam int CntW = mro_pkg::CntW;
  localparam int HgtW = mro_pkg::HgtW;

  mro_pkg::state_t       state;
  logic [8:0]            columns_in_use;
  logic [ColW-1:0]       pos;
  logic                  bit_r;
  logic                  last_r;
  logic [CntW-1:0]       scan_n;
  logic [CntW-1:0]       scan_i;
  logic [ColW-1:0]       start_r;
  mro_pkg::stack_entry_t top;
  logic [CntW-1:0]       depth;

  logic                  accept;
  logic [CntW-1:0]       cols;
  logic                  row_end;
  logic [HgtW-1:0]       h_rd;
  logic [HgtW-1:0]       h_new;
  logic [HgtW-1:0]       cur_h;
  logic                  in_row;
  logic                  do_pop;
  logic                  h_rd_en;
  logic [ColW-1:0]       h_rd_addr;
  logic                  h_wr_en;
  logic                  stk_wr_en;
  logic                  stk_rd_en;
  logic [CntW-1:0]       stk_rd_ptr;
  mro_pkg::stack_entry_t stk_wr_data;
  mro_pkg::stack_entry_t stk_rd_data;
  mro_pkg::pop_t         pop;
  logic [16:0]           best_next;
  logic                  emit;
  logic                  clear;

  assign in_stall = (state != mro_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Effective row length, clamped to the legal range.
  always_comb begin
    if (columns_in_use == '0) begin
      cols = CntW'(1);
    end else if (columns_in_use > 9'(mro_pkg::MaxCols)) begin
      cols = CntW'(mro_pkg::MaxCols);
    end else begin
      cols = CntW'(columns_in_use);
    end
  end

  assign row_end = (CntW'(pos) + CntW'(1)) >= cols;

  always_comb begin
    if (!bit_r) begin
      h_new = '0;
    end else if (h_rd < HgtW'(mro_pkg::MaxRows)) begin
      h_new = h_rd + HgtW'(1);
    end else begin
      h_new = h_rd;
    end
  end

  // Past the last column the scan sees a zero bar, which empties the stack.
  assign in_row = scan_i < scan_n;
  assign cur_h  = in_row ? h_rd : '0;
  assign do_pop = (state == mro_pkg::S_CMP) && (depth != '0) && (top.height >= cur_h);

  assign h_rd_en   = accept || (state == mro_pkg::S_RD && in_row);
  assign h_rd_addr = (state == mro_pkg::S_IDLE) ? pos : scan_i[ColW-1:0];
  assign h_wr_en   = (state == mro_pkg::S_UPD);

  assign stk_wr_en         = (state == mro_pkg::S_CMP) && !do_pop && in_row;
  assign stk_wr_data.start  = start_r;
  assign stk_wr_data.height = cur_h;
  assign stk_rd_en         = do_pop;
  assign stk_rd_ptr        = depth - CntW'(2);

  assign pop.fire   = do_pop;
  assign pop.height = top.height;
  assign pop.width  = scan_i - CntW'(top.start);

  assign emit  = (state == mro_pkg::S_FIN) && last_r && !(out_valid && out_stall);
  assign clear = emit;

  mro_height_mem u_heights (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .wr_en   (h_wr_en),
    .wr_addr (pos),
    .wr_data (h_new),
    .rd_en   (h_rd_en),
    .rd_addr (h_rd_addr),
    .rd_data (h_rd)
  );

  mro_stack_mem u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (depth[ColW-1:0]),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_ptr[ColW-1:0]),
    .rd_data (stk_rd_data)
  );

  mro_area_unit u_area (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .pop       (pop),
    .best_next (best_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= 9'(mro_pkg::MaxCols);
    end else if (cfg_write_en) begin
      columns_in_use <= cfg_write_data;
    end
  end

  // Payload-side registers of the scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      bit_r  <= cell_bit;
      last_r <= final_cell;
    end
    if (state == mro_pkg::S_UPD) begin
      scan_n <= CntW'(pos) + CntW'(1);
    end
    if (state == mro_pkg::S_RD) begin
      start_r <= scan_i[ColW-1:0];
    end else if (do_pop) begin
      start_r <= top.start;
    end
    if (stk_wr_en) begin
      top <= stk_wr_data;
    end else if (state == mro_pkg::S_POP) begin
      top <= stk_rd_data;
    end
    if (emit) begin
      largest_area <= best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mro_pkg::S_IDLE;
      pos       <= '0;
      scan_i    <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        mro_pkg::S_IDLE: begin
          if (accept) begin
            state <= mro_pkg::S_UPD;
          end
        end
        mro_pkg::S_UPD: begin
          pos <= row_end ? '0 : pos + ColW'(1);
          if (row_end || last_r) begin
            scan_i <= '0;
            depth  <= '0;
            state  <= mro_pkg::S_RD;
          end else begin
            state <= mro_pkg::S_IDLE;
          end
        end
        mro_pkg::S_RD: begin
          state <= mro_pkg::S_CMP;
        end
        mro_pkg::S_CMP: begin
          if (do_pop) begin
            depth <= depth - CntW'(1);
            state <= mro_pkg::S_POP;
          end else if (in_row) begin
            depth  <= depth + CntW'(1);
            scan_i <= scan_i + CntW'(1);
            state  <= mro_pkg::S_RD;
          end else begin
            state <= mro_pkg::S_FIN;
          end
        end
        mro_pkg::S_POP: begin
          state <= mro_pkg::S_CMP;
        end
        mro_pkg::S_FIN: begin
          if (!last_r) begin
            state <= mro_pkg::S_IDLE;
          end else if (emit) begin
            pos   <= '0;
            state <= mro_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mro_pkg::S_IDLE;
        end
      endcase
    end
  end

  // The stack never holds more entries than the maximum column count.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CntW'(mro_pkg::MaxCols))
    else $error("stack depth beyond the column count");

  // The scan never steps past the closing zero bar.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mro_pkg::S_CMP) |-> (scan_i <= scan_n))
    else $error("scan index past the end of the row");

  // A pop shrinks the stack by one and reloads the new top.
  a_pop_reload: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> (state == mro_pkg::S_POP) && (depth == $past(depth) - CntW'(1)))
    else $error("pop did not reload the stack top");

  // A result only appears after the scan of a final cell.
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mro_pkg::S_FIN && last_r))
    else $error("result presented without a final cell");

endmodule
